FILE: sv/kvt_pkg.sv
// Shared types and codes of the keyed value table.
package kvt_pkg;

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 6;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_INSERT = 3'd0;
  localparam op_t OP_ERASE  = 3'd1;
  localparam op_t OP_LOOKUP = 3'd2;
  localparam op_t OP_TEST   = 3'd3;
  localparam op_t OP_COUNT  = 3'd4;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_DUP     = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_MISSING = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

FILE: sv/kvt_if.sv
// Valid/ready channel interfaces for operations and results of the keyed value table.
interface kvt_in_if;
  logic                         valid;
  logic                         ready;
  logic [kvt_pkg::OP_W-1:0]     operation;
  logic [kvt_pkg::KEY_W-1:0]    key;
  logic [kvt_pkg::VAL_W-1:0]    value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface kvt_out_if;
  logic                         valid;
  logic                         ready;
  logic [kvt_pkg::STATUS_W-1:0] status;
  logic [kvt_pkg::VAL_W-1:0]    read_value;
  logic [kvt_pkg::CNT_W-1:0]    match_count;
  logic [kvt_pkg::CNT_W-1:0]    entries;

  modport source (output valid, output status, output read_value, output match_count,
                  output entries, input ready);
  modport sink   (input valid, input status, input read_value, input match_count,
                  input entries, output ready);
endinterface

FILE: sv/keyed_value_table_core.sv
// Top level of the keyed value table: operation sequencer, entry memory and result register.
//
// Usage: each transaction on in_ch carries one operation (insert, erase, lookup, key test
// or value count) with a key and a value; each produces exactly one transaction on out_ch
// carrying a status, the looked-up value, a match count and the entry count afterwards.
// Entries sit packed in slots 0 to entries-1 of one synchronous memory of key/value pairs.
// An operation that needs the table reads every valid slot once, one slot a cycle through
// the memory's single read port, so the scan of N entries, N being the entries held, sets the rate.
// The last slot's contents are captured during the scan, so an erase can move it into the
// freed slot without a further read. Insert into a full table skips the scan.
// The scan is skipped when the table is empty, for an insert into a full table and for an
// unused operation code; the sequencer then goes straight from idle to the result.
// in_ch.ready is high only while the sequencer is idle. The result waits in an output
// register; a new transaction may be accepted while it waits, but the following result is
// held back, and the sequencer with it, until the receiver takes the waiting one.
// Reset (rst_n low, synchronous) empties the table and drops any pending result; the
// memory contents are left as they are and are never read before being written.
module keyed_value_table_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  kvt_in_if.sink       in_ch,
  kvt_out_if.source    out_ch
);

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // Control state.
  logic [1:0]            state_r,    state_nxt;
  logic [CntW-1:0]       count_r,    count_nxt;
  logic                  pend_r,     pend_nxt;
  logic                  out_vld_r,  out_vld_nxt;

  // Operation and scan registers.
  kvt_pkg::op_t          op_r,       op_nxt;
  logic [kvt_pkg::KEY_W-1:0] key_r,  key_nxt;
  logic [kvt_pkg::VAL_W-1:0] val_r,  val_nxt;
  logic [AddrW-1:0]      idx_r,      idx_nxt;
  logic [AddrW-1:0]      pidx_r,     pidx_nxt;
  logic                  hit_r,      hit_nxt;
  logic [AddrW-1:0]      slot_r,     slot_nxt;
  logic [kvt_pkg::VAL_W-1:0] hval_r, hval_nxt;
  logic [CntW-1:0]       match_r,    match_nxt;
  kvt_pkg::entry_t       last_r,     last_nxt;

  // Result register.
  kvt_pkg::status_t      o_status_r, o_status_nxt;
  logic [kvt_pkg::VAL_W-1:0] o_rval_r, o_rval_nxt;
  logic [kvt_pkg::CNT_W-1:0] o_match_r, o_match_nxt;
  logic [kvt_pkg::CNT_W-1:0] o_ent_r, o_ent_nxt;

  // Memory ports.
  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;
  kvt_pkg::entry_t       rd_data;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  kvt_pkg::entry_t       wr_data;

  logic                  in_take;
  logic                  full;
  logic [AddrW-1:0]      last_idx;
  logic                  scan_op;
  logic                  out_free;
  logic [CntW-1:0]       new_count;

  kvt_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CntW'(TABLE_DEPTH));
  assign last_idx    = AddrW'(count_r - CntW'(1));
  assign out_free    = !out_vld_r || out_ch.ready;

  // Every operation but an insert into a full table and the unused codes scans the table.
  always_comb begin
    scan_op = 1'b0;
    case (in_ch.operation) inside
      kvt_pkg::OP_INSERT: scan_op = !full;
      kvt_pkg::OP_ERASE, kvt_pkg::OP_LOOKUP,
      kvt_pkg::OP_TEST, kvt_pkg::OP_COUNT: scan_op = 1'b1;
      default: scan_op = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pend_nxt     = 1'b0;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    op_nxt       = op_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    pidx_nxt     = pidx_r;
    hit_nxt      = hit_r;
    slot_nxt     = slot_r;
    hval_nxt     = hval_r;
    match_nxt    = match_r;
    last_nxt     = last_r;
    o_status_nxt = o_status_r;
    o_rval_nxt   = o_rval_r;
    o_match_nxt  = o_match_r;
    o_ent_nxt    = o_ent_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = slot_r;
    wr_data      = last_r;
    new_count    = count_r;

    // Compare the slot read in the previous cycle, whatever the state.
    if (pend_r) begin
      if (rd_data.key == key_r) begin
        hit_nxt  = 1'b1;
        slot_nxt = pidx_r;
        hval_nxt = rd_data.value;
      end
      if (rd_data.value == val_r) begin
        match_nxt = match_r + CntW'(1);
      end
      if (pidx_r == last_idx) begin
        last_nxt = rd_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_nxt    = in_ch.operation;
          key_nxt   = in_ch.key;
          val_nxt   = in_ch.value;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          match_nxt = '0;
          state_nxt = (scan_op && count_r != '0) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        rd_en    = 1'b1;
        pend_nxt = 1'b1;
        pidx_nxt = idx_r;
        if (idx_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + AddrW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          o_status_nxt = kvt_pkg::ST_OK;
          o_rval_nxt   = '0;
          o_match_nxt  = '0;
          case (op_r)
            kvt_pkg::OP_INSERT: begin
              if (full) begin
                o_status_nxt = kvt_pkg::ST_FULL;
              end else if (hit_r) begin
                o_status_nxt = kvt_pkg::ST_DUP;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = AddrW'(count_r);
                wr_data   = '{key: key_r, value: val_r};
                new_count = count_r + CntW'(1);
              end
            end
            kvt_pkg::OP_ERASE: begin
              if (!hit_r) begin
                o_status_nxt = kvt_pkg::ST_MISSING;
              end else begin
                // The last entry fills the freed slot; harmless when they coincide.
                wr_en     = 1'b1;
                wr_addr   = slot_r;
                wr_data   = last_r;
                new_count = count_r - CntW'(1);
              end
            end
            kvt_pkg::OP_LOOKUP: begin
              if (!hit_r) begin
                o_status_nxt = kvt_pkg::ST_MISSING;
              end else begin
                o_rval_nxt = hval_r;
              end
            end
            kvt_pkg::OP_TEST: begin
              if (!hit_r) begin
                o_status_nxt = kvt_pkg::ST_MISSING;
              end
            end
            kvt_pkg::OP_COUNT: begin
              o_match_nxt = kvt_pkg::CNT_W'(match_r);
            end
            default: begin
              o_status_nxt = kvt_pkg::ST_OK;
            end
          endcase
          count_nxt   = new_count;
          o_ent_nxt   = kvt_pkg::CNT_W'(new_count);
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    hval_r     <= hval_nxt;
    match_r    <= match_nxt;
    last_r     <= last_nxt;
    o_status_r <= o_status_nxt;
    o_rval_r   <= o_rval_nxt;
    o_match_r  <= o_match_nxt;
    o_ent_r    <= o_ent_nxt;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.read_value  = o_rval_r;
  assign out_ch.match_count = o_match_r;
  assign out_ch.entries     = o_ent_r;

endmodule

FILE: sv/kvt_store.sv
// Entry memory of the keyed value table: one write port, one registered read port.
module kvt_store #(
  parameter int TABLE_DEPTH = 32,
  localparam int AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AddrW-1:0]      rd_addr,
  output kvt_pkg::entry_t       rd_data,
  input  logic                  wr_en,
  input  logic [AddrW-1:0]      wr_addr,
  input  kvt_pkg::entry_t       wr_data
);

  kvt_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
